### rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int CELL_W = 16;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    typedef logic [CELL_W-1:0] t_cell;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_cmd;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_col_out;
    } t_result;

endpackage

### rtl/tcw_screen_ram.sv
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  tcw_pkg::t_cell      i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output tcw_pkg::t_cell      o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/text_console_writer.sv
// text console writer: ROWS x COLUMNS screen of 16-bit cells plus a cursor
// command channel: an item (i_cmd) is taken at a clock edge with start high
// and busy low; operations are put character, clear screen, read cell
// result channel: one result beat per item, o_result valid while o_strobe is
// high for exactly one cycle; there is no back pressure
// config: i_cfg_we / i_cfg_wdata write the attribute byte; the user must do so only while idle, not enforced
// order of work, set by the single-port write / single-port read screen memory:
//   put without scroll, newline without scroll, unknown operation: result in
//   the cycle after the item, busy stays low, one item per cycle
//   read cell: the memory read is registered (S_RD), then the result is registered
//   put or newline past the last row: rows are moved up by one row (S_MOVE),
//   then the bottom row is blanked (S_FILL), then the result is registered
//   clear: every cell is blanked (S_FILL), then the result is registered
// reset: busy is held high during reset and after it while a clearing pass
// writes blanks with attribute 7; no result is given for it
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tcw_pkg::t_cmd     i_cmd,
    output logic              busy,
    output logic              o_strobe,
    output tcw_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata
);
    import tcw_pkg::*;

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int MOVE_CNT = (ROWS - 1) * COLUMNS;
    localparam int AW       = $clog2(CELLS);
    localparam int RW       = $clog2(ROWS);
    localparam int CW       = $clog2(COLUMNS);

    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] MOVE_LAST = AW'(MOVE_CNT - 1);
    localparam logic [AW-1:0] MOVE_A    = AW'(MOVE_CNT);
    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;
    localparam logic [1:0] S_FILL = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic          r_init, n_init;
    logic          r_mv_pend, n_mv_pend;
    logic [AW-1:0] r_mv_addr, n_mv_addr;
    logic          r_rd_ok, n_rd_ok;
    logic          r_strobe, n_strobe;
    t_result       r_res, n_res;
    logic [7:0]    r_attr;

    logic          accept;
    logic          emit;
    logic [15:0]   emit_cell;
    logic          rd_in_range;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] rd_addr;
    t_cell         blank;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_cell         mem_wdata, mem_rdata;

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy   = (r_state != S_IDLE) || !i_rst_n;
    assign accept = start && !busy;

    assign cur_addr    = AW'(r_row) * COLS_A + AW'(r_col);
    assign rd_in_range = (32'(i_cmd.read_row) < 32'(ROWS))
                      && (32'(i_cmd.read_col) < 32'(COLUMNS));
    assign rd_addr     = AW'(i_cmd.read_row) * COLS_A + AW'(i_cmd.read_col);
    assign blank       = r_init ? {RESET_ATTR, SPACE_CODE} : {r_attr, SPACE_CODE};

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_row     = r_row;
        n_col     = r_col;
        n_init    = r_init;
        n_mv_pend = 1'b0;
        n_mv_addr = r_idx;
        n_rd_ok   = r_rd_ok;
        n_strobe  = 1'b0;
        n_res     = r_res;
        emit      = 1'b0;
        emit_cell = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        // moved cell from the previous read lands one row up
        if (r_mv_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_mv_addr;
            mem_wdata = mem_rdata;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.operation)
                        OP_PUT: begin
                            if (i_cmd.char_code != NEWLINE_CODE) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {r_attr, i_cmd.char_code};
                            end
                            if (i_cmd.char_code != NEWLINE_CODE && r_col != COL_LAST) begin
                                n_col = r_col + 1'b1;
                                emit  = 1'b1;
                            end else if (r_row == ROW_LAST) begin
                                n_col   = '0;
                                n_idx   = '0;
                                n_state = S_MOVE;
                            end else begin
                                n_row = r_row + 1'b1;
                                n_col = '0;
                                emit  = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_idx   = '0;
                            n_state = S_FILL;
                        end
                        OP_READ: begin
                            mem_re    = rd_in_range;
                            mem_raddr = rd_addr;
                            n_rd_ok   = rd_in_range;
                            n_state   = S_RD;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                emit      = 1'b1;
                emit_cell = r_rd_ok ? mem_rdata : '0;
                n_state   = S_IDLE;
            end
            S_MOVE: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx + COLS_A;
                n_mv_pend = 1'b1;
                n_mv_addr = r_idx;
                if (r_idx == MOVE_LAST) begin
                    n_idx   = MOVE_A;
                    n_state = S_FILL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FILL: begin
                // the last moved cell takes the write port first; filling waits until it is written
                if (!r_mv_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = blank;
                    if (r_idx == CELL_LAST) begin
                        n_state = S_IDLE;
                        n_init  = 1'b0;
                        emit    = !r_init;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_strobe             = 1'b1;
            n_res.cell_value     = emit_cell;
            n_res.cursor_row_out = 5'(n_row);
            n_res.cursor_col_out = 7'(n_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL;
            r_idx     <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_init    <= 1'b1;
            r_mv_pend <= 1'b0;
            r_strobe  <= 1'b0;
            r_attr    <= RESET_ATTR;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_row     <= n_row;
            r_col     <= n_col;
            r_init    <= n_init;
            r_mv_pend <= n_mv_pend;
            r_strobe  <= n_strobe;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mv_addr <= n_mv_addr;
        r_rd_ok   <= n_rd_ok;
        r_res     <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_init_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |=> !r_strobe)
        else $error("result beat during reset clearing pass");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_strobe && r_state == S_IDLE))
        else $error("read cell did not complete in one cycle");

    a_move_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv_pend |-> (r_state == S_MOVE || r_state == S_FILL))
        else $error("pending row move outside of scroll");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < 32'(ROWS)) && (32'(r_col) < 32'(COLUMNS)))
        else $error("cursor outside the screen");

endmodule
